[rtl/tlwsb_pkg.sv]
// Shared types and constants of the greedy line wrap span builder.
// Used by text_line_wrap_span_builder and tlwsb_checker; no dependencies.
package tlwsb_pkg;

    localparam int unsigned TEXT_CAPACITY_DEF = 98304;
    localparam int unsigned SPAN_LIMIT_DEF    = 8192;

    localparam int unsigned POS_W    = 17;
    localparam int unsigned LEN_W    = 10;
    localparam int unsigned STYLE_W  = 4;
    localparam int unsigned LINK_W   = 8;
    localparam int unsigned X_W      = 12;
    localparam int unsigned Y_W      = 21;
    localparam int unsigned CHAR_W   = 8;

    localparam int unsigned S_DATA_W = 24;
    localparam int unsigned M_DATA_W = 96;
    localparam int unsigned M_USED_W = POS_W + LEN_W + STYLE_W + LINK_W + X_W + Y_W + Y_W;

    localparam logic [X_W-1:0]    GLYPH_W      = X_W'(8);
    localparam logic [Y_W-1:0]    LINE_H       = Y_W'(16);
    localparam logic [X_W-1:0]    LEFT_X       = X_W'(4);
    localparam logic [X_W-1:0]    MIN_WIDTH    = X_W'(48);
    localparam logic [X_W-1:0]    RIGHT_MARGIN = X_W'(8);
    localparam logic [X_W-1:0]    WIDTH_RESET  = X_W'(640);
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = CHAR_W'(10);
    localparam logic [CHAR_W-1:0] CH_SPACE     = CHAR_W'(32);

    typedef enum logic
    {
        ACT_CHAR   = 1'b0,
        ACT_FINISH = 1'b1
    } action_t;

    typedef enum logic
    {
        KIND_SPAN   = 1'b0,
        KIND_HEIGHT = 1'b1
    } kind_t;

    typedef struct packed
    {
        kind_t              kind;
        logic               last;
        logic [POS_W-1:0]   span_offset;
        logic [LEN_W-1:0]   span_length;
        logic [STYLE_W-1:0] span_style;
        logic [LINK_W-1:0]  span_link;
        logic [X_W-1:0]     span_x;
        logic [Y_W-1:0]     span_y;
        logic [Y_W-1:0]     height;
    } result_t;

endpackage

[rtl/text_line_wrap_span_builder.sv]
// Greedy fixed-width line wrap: turns a character stream into span records.
// Depends on tlwsb_pkg.
//
// Usage:
//   Slave channel s_*: one request per character or finish. s_tuser is the
//   action (0 character, 1 finish), s_tdata carries char_code, style, link_id.
//   Master channel m_*: span records (m_tuser 0) and height reports
//   (m_tuser 1); m_tlast marks the final result of one request.
//   cfg_we/cfg_wdata writes wrap_width and restarts the layout; write only
//   while the block is idle.
//   Results of a request are registered in the result queue on acceptance,
//   behind any earlier results. A character gives at most one result, so
//   characters flow one per cycle while s_tready is high; a finish gives
//   up to two results. The rate is set by the three-entry result queue:
//   s_tready is high while it holds at most one result, so a stalled receiver
//   stops intake after at most three waiting results, and nothing is lost.
//   Reset: queue empty, wrap_width 640, cursor at x 4, y 0, no pending span.
module text_line_wrap_span_builder #(
    parameter int unsigned TEXT_CAPACITY = tlwsb_pkg::TEXT_CAPACITY_DEF,
    parameter int unsigned SPAN_LIMIT    = tlwsb_pkg::SPAN_LIMIT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tlwsb_pkg::S_DATA_W-1:0] s_tdata,  // char_code, style, link_id
    input  logic                          s_tuser,  // action
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // span_offset, span_length, span_style, span_link, span_x, span_y, height
    output logic [tlwsb_pkg::M_DATA_W-1:0] m_tdata,
    output logic                          m_tuser,  // kind
    output logic                          m_tlast,
    input  logic                          cfg_we,
    input  logic [tlwsb_pkg::X_W-1:0]      cfg_wdata
);

    localparam int unsigned POS_W  = tlwsb_pkg::POS_W;
    localparam int unsigned LEN_W  = tlwsb_pkg::LEN_W;
    localparam int unsigned ST_W   = tlwsb_pkg::STYLE_W;
    localparam int unsigned LK_W   = tlwsb_pkg::LINK_W;
    localparam int unsigned X_W    = tlwsb_pkg::X_W;
    localparam int unsigned Y_W    = tlwsb_pkg::Y_W;
    localparam int unsigned CH_W   = tlwsb_pkg::CHAR_W;
    localparam int unsigned SPAN_W = $clog2(SPAN_LIMIT + 1);
    localparam logic [POS_W-1:0]  TEXT_LAST = POS_W'(TEXT_CAPACITY - 1);
    localparam logic [SPAN_W-1:0] SPAN_MAX  = SPAN_W'(SPAN_LIMIT);

    logic [X_W-1:0]    width_reg;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [X_W-1:0]    cur_x_reg, cur_x_next;
    logic [Y_W-1:0]    cur_y_reg, cur_y_next;
    logic [LEN_W-1:0]  pend_cnt_reg, pend_cnt_next;
    logic [POS_W-1:0]  pend_off_reg, pend_off_next;
    logic [ST_W-1:0]   pend_st_reg, pend_st_next;
    logic [LK_W-1:0]   pend_lk_reg, pend_lk_next;
    logic [X_W-1:0]    pend_x_reg, pend_x_next;
    logic [Y_W-1:0]    pend_y_reg, pend_y_next;
    logic [SPAN_W-1:0] spans_reg, spans_next;
    logic              stopped_reg, stopped_next;

    tlwsb_pkg::result_t q_reg [3];
    tlwsb_pkg::result_t q_next [3];
    logic [1:0]         count_reg, count_next;

    tlwsb_pkg::result_t res0, res1;
    logic [1:0]         push_n;

    logic               in_fire, out_fire;
    logic [CH_W-1:0]    in_char;
    logic [ST_W-1:0]    in_style;
    logic [LK_W-1:0]    in_link;
    logic [X_W-1:0]     width_sat;

    assign in_char  = s_tdata[CH_W-1:0];
    assign in_style = s_tdata[CH_W+ST_W-1:CH_W];
    assign in_link  = s_tdata[CH_W+ST_W+LK_W-1:CH_W+ST_W];

    assign s_tready = (count_reg <= 2'd1);
    assign in_fire  = s_tvalid && s_tready;
    assign m_tvalid = (count_reg != 2'd0);
    assign out_fire = m_tvalid && m_tready;

    assign m_tuser = q_reg[0].kind;
    assign m_tlast = q_reg[0].last;
    assign m_tdata = {(tlwsb_pkg::M_DATA_W - tlwsb_pkg::M_USED_W)'(0),
                      q_reg[0].height, q_reg[0].span_y, q_reg[0].span_x,
                      q_reg[0].span_link, q_reg[0].span_style,
                      q_reg[0].span_length, q_reg[0].span_offset};

    assign width_sat = (cfg_wdata < tlwsb_pkg::MIN_WIDTH) ? tlwsb_pkg::MIN_WIDTH : cfg_wdata;

    always_comb
    begin
        tlwsb_pkg::result_t span_res, hgt_res;
        logic               fl_any, fl_emit, fl_stop, do_flush;
        logic               active, is_nl, is_wrap, differ, skip;
        logic [X_W:0]       x_end;
        logic [X_W-1:0]     x_lim, x_base;
        logic [Y_W-1:0]     y_base;

        span_res             = '0;
        span_res.kind        = tlwsb_pkg::KIND_SPAN;
        span_res.span_offset = pend_off_reg;
        span_res.span_length = pend_cnt_reg;
        span_res.span_style  = pend_st_reg;
        span_res.span_link   = pend_lk_reg;
        span_res.span_x      = pend_x_reg;
        span_res.span_y      = pend_y_reg;

        hgt_res        = '0;
        hgt_res.kind   = tlwsb_pkg::KIND_HEIGHT;
        hgt_res.last   = 1'b1;
        hgt_res.height = cur_y_reg + tlwsb_pkg::LINE_H;

        fl_any  = (pend_cnt_reg != '0) && !stopped_reg;
        fl_emit = fl_any && (spans_reg < SPAN_MAX);
        fl_stop = fl_any && !(spans_reg < SPAN_MAX);

        active  = !stopped_reg && (pos_reg < TEXT_LAST);
        is_nl   = (in_char == tlwsb_pkg::CH_NEWLINE);
        x_end   = {1'b0, cur_x_reg} + {1'b0, tlwsb_pkg::GLYPH_W};
        x_lim   = width_reg - tlwsb_pkg::RIGHT_MARGIN;
        is_wrap = !is_nl && (x_end > {1'b0, x_lim});
        differ  = (pend_st_reg != in_style) || (pend_lk_reg != in_link)
                  || (pend_y_reg != cur_y_reg);
        skip    = is_nl || (is_wrap && (in_char == tlwsb_pkg::CH_SPACE));

        pos_next      = pos_reg;
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        pend_cnt_next = pend_cnt_reg;
        pend_off_next = pend_off_reg;
        pend_st_next  = pend_st_reg;
        pend_lk_next  = pend_lk_reg;
        pend_x_next   = pend_x_reg;
        pend_y_next   = pend_y_reg;
        spans_next    = spans_reg;
        stopped_next  = stopped_reg;
        res0          = span_res;
        res1          = hgt_res;
        push_n        = 2'd0;
        x_base        = cur_x_reg;
        y_base        = cur_y_reg;
        do_flush      = 1'b0;

        if (tlwsb_pkg::action_t'(s_tuser) == tlwsb_pkg::ACT_FINISH)
        begin
            pend_cnt_next = '0;
            spans_next    = spans_reg + SPAN_W'(fl_emit);
            stopped_next  = stopped_reg || fl_stop;
            if (fl_emit)
            begin
                push_n = 2'd2;
            end
            else
            begin
                res0   = hgt_res;
                push_n = 2'd1;
            end
        end
        else if (active)
        begin
            if (is_nl || is_wrap)
            begin
                do_flush   = 1'b1;
                x_base     = tlwsb_pkg::LEFT_X;
                y_base     = cur_y_reg + tlwsb_pkg::LINE_H;
                pend_cnt_next = '0;
            end
            else if (pend_cnt_reg != '0 && differ)
            begin
                do_flush = 1'b1;
            end

            cur_x_next = x_base;
            cur_y_next = y_base;
            pos_next   = pos_reg + POS_W'(1);

            if (!skip)
            begin
                if (do_flush || pend_cnt_reg == '0)
                begin
                    pend_off_next = pos_reg;
                    pend_st_next  = in_style;
                    pend_lk_next  = in_link;
                    pend_x_next   = x_base;
                    pend_y_next   = y_base;
                    pend_cnt_next = LEN_W'(1);
                end
                else
                begin
                    pend_cnt_next = pend_cnt_reg + LEN_W'(1);
                end
                cur_x_next = x_base + tlwsb_pkg::GLYPH_W;
            end

            if (do_flush)
            begin
                spans_next   = spans_reg + SPAN_W'(fl_emit);
                stopped_next = stopped_reg || fl_stop;
                res0.last    = 1'b1;
                push_n       = fl_emit ? 2'd1 : 2'd0;
            end
        end
    end

    always_comb
    begin
        logic [1:0] base;

        base = count_reg - 2'(out_fire);
        for (int i = 0; i < 3; i++)
        begin
            q_next[i] = (out_fire && i < 2) ? q_reg[(i < 2) ? i + 1 : i] : q_reg[i];
        end
        if (in_fire && push_n != 2'd0)
        begin
            q_next[base] = res0;
            if (push_n == 2'd2)
            begin
                q_next[2'(base + 2'd1)] = res1;
            end
        end
        count_next = base + (in_fire ? push_n : 2'd0);
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= tlwsb_pkg::WIDTH_RESET;
            pos_reg      <= '0;
            cur_x_reg    <= tlwsb_pkg::LEFT_X;
            cur_y_reg    <= '0;
            pend_cnt_reg <= '0;
            pend_off_reg <= '0;
            pend_st_reg  <= '0;
            pend_lk_reg  <= '0;
            pend_x_reg   <= tlwsb_pkg::LEFT_X;
            pend_y_reg   <= '0;
            spans_reg    <= '0;
            stopped_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            width_reg    <= width_sat;
            pos_reg      <= '0;
            cur_x_reg    <= tlwsb_pkg::LEFT_X;
            cur_y_reg    <= '0;
            pend_cnt_reg <= '0;
            pend_off_reg <= '0;
            pend_st_reg  <= '0;
            pend_lk_reg  <= '0;
            pend_x_reg   <= tlwsb_pkg::LEFT_X;
            pend_y_reg   <= '0;
            spans_reg    <= '0;
            stopped_reg  <= 1'b0;
        end
        else if (in_fire)
        begin
            pos_reg      <= pos_next;
            cur_x_reg    <= cur_x_next;
            cur_y_reg    <= cur_y_next;
            pend_cnt_reg <= pend_cnt_next;
            pend_off_reg <= pend_off_next;
            pend_st_reg  <= pend_st_next;
            pend_lk_reg  <= pend_lk_next;
            pend_x_reg   <= pend_x_next;
            pend_y_reg   <= pend_y_next;
            spans_reg    <= spans_next;
            stopped_reg  <= stopped_next;
        end
    end

endmodule

[rtl/tlwsb_checker.sv]
// Port-level checks of the line wrap span builder, bound to its top level.
// Depends on tlwsb_pkg and text_line_wrap_span_builder.
module tlwsb_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [tlwsb_pkg::M_DATA_W-1:0] m_tdata,
    input logic                           m_tuser,
    input logic                           m_tlast
);

    // height report always closes its request
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("height report without tlast");

    // a span not closing its request is followed at once by the height report
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tuser))
        else $error("span without tlast not followed by height report");

    // height report: span fields zero, height non-zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |->
        (m_tdata[71:0] == 72'd0 && m_tdata[92:72] != 21'd0))
        else $error("malformed height report");

    // span record: height zero, length non-zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |->
        (m_tdata[92:72] == 21'd0 && m_tdata[26:17] != 10'd0))
        else $error("malformed span record");

    assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("result presented during reset");

endmodule

bind text_line_wrap_span_builder tlwsb_checker u_tlwsb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
